// File: hdl/ntc_pkg.sv
// Shared types, constants and the thermistor curve for the NTC temperature cutoff.
package ntc_pkg;

   // Default values of the top-level parameters
   localparam int SAMPLES_PER_READING_DEF = 10;
   localparam int TABLE_ENTRIES_DEF       = 121;
   localparam int CHANNEL_COUNT_DEF       = 3;

   // Fixed field widths
   localparam int CH_W     = 2;
   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int TEMP_W   = 7;
   localparam int LIMIT_W  = 7;
   localparam int MASK_W   = 3;
   localparam int CHAN_MAX = 3;
   localparam int ROM_SIZE = 121;
   localparam int ROM_W    = 10;
   localparam int ROM_IDX_W = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd100;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_LIMIT_CH0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_LIMIT_CH1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_LIMIT_CH2 = 2'd2;

   // Channel numbers
   localparam logic [CH_W-1:0] CH0 = 2'd0;
   localparam logic [CH_W-1:0] CH1 = 2'd1;
   localparam logic [CH_W-1:0] CH2 = 2'd2;

   // Ascending thermistor curve, one entry per degree from 0 to 120
   localparam logic [ROM_W-1:0] CURVE_ROM [ROM_SIZE] = '{
      10'd282, 10'd291, 10'd300, 10'd309, 10'd318, 10'd327, 10'd337, 10'd346, 10'd356,
      10'd366, 10'd375, 10'd385, 10'd395, 10'd404, 10'd414, 10'd424, 10'd434, 10'd444,
      10'd454, 10'd463, 10'd473, 10'd483, 10'd493, 10'd502, 10'd512, 10'd522, 10'd531,
      10'd541, 10'd550, 10'd559, 10'd568, 10'd578, 10'd587, 10'd596, 10'd604, 10'd613,
      10'd622, 10'd630, 10'd639, 10'd647, 10'd655, 10'd663, 10'd671, 10'd679, 10'd687,
      10'd694, 10'd702, 10'd709, 10'd716, 10'd723, 10'd730, 10'd737, 10'd743, 10'd750,
      10'd756, 10'd763, 10'd769, 10'd775, 10'd781, 10'd786, 10'd792, 10'd797, 10'd803,
      10'd808, 10'd813, 10'd818, 10'd823, 10'd828, 10'd833, 10'd837, 10'd842, 10'd846,
      10'd850, 10'd854, 10'd858, 10'd862, 10'd866, 10'd870, 10'd874, 10'd877, 10'd881,
      10'd884, 10'd888, 10'd891, 10'd894, 10'd897, 10'd900, 10'd903, 10'd906, 10'd909,
      10'd911, 10'd914, 10'd917, 10'd919, 10'd921, 10'd924, 10'd926, 10'd928, 10'd931,
      10'd933, 10'd935, 10'd937, 10'd939, 10'd941, 10'd943, 10'd945, 10'd946, 10'd948,
      10'd950, 10'd952, 10'd953, 10'd955, 10'd956, 10'd958, 10'd959, 10'd961, 10'd962,
      10'd964, 10'd965, 10'd966, 10'd967
   };

   // Read the curve; an index past the end reads the last entry
   function automatic logic [ROM_W-1:0] curve_at(input logic [ROM_IDX_W-1:0] idx);
      logic [ROM_W-1:0] val;
      if (idx < ROM_IDX_W'(ROM_SIZE)) begin
         val = CURVE_ROM[idx];
      end else begin
         val = CURVE_ROM[ROM_SIZE-1];
      end
      return val;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHK_LOW,
      ST_CHK_HIGH,
      ST_SEARCH,
      ST_HOLD
   } eng_state_type;

   // Accumulator view of the sample being accepted
   typedef struct packed {
      logic             complete;
      logic [SUM_W-1:0] total;
   } acc_status_type;

   // Lookup engine status toward the top level
   typedef struct packed {
      logic              idle;
      logic              res_valid;
      logic [TEMP_W-1:0] temp;
      logic              oor;
   } eng_status_type;

endpackage

// File: hdl/ntc_temperature_cutoff.sv
// Top level of the three-channel NTC thermistor temperature cutoff.
//
// Each req item carries one 12-bit converter sample on req_tdata and its
// thermistor channel on req_tuser. Per channel the block sums samples; a
// sample that is not the last of a reading is taken with no lookup and gives
// no rsp item, and a channel code at or above CHANNEL_COUNT is dropped
// without effect. The SAMPLES_PER_READING-th sample of a channel clears that
// channel's sum and starts a lookup: the sum is divided by
// SAMPLES_PER_READING with one multiply by a fixed reciprocal, the average
// is checked against both ends of the curve, then a binary search over the
// curve narrows to the degree interval, and the result waits in the hold
// state until it can move into the output register. The compares all run on
// one shared compare unit, so a completing sample keeps req_tready low until
// its result has moved into the rsp output register, longer while that
// register is still full. An average
// below the first entry reads as 0 degrees and one at or above the last as
// the top degree, both with out_of_range set. The temperature is then
// compared with the channel's alarm limit: at or above it the channel's
// bit in power_mask is cleared, otherwise set; all loads are off after
// reset. The rsp item is held in an output register, so the next sample is
// taken while it waits. Alarm limits (reset 100) are written on the csr
// port, index 0..2 for channels 0..2; other indexes are ignored. Write them
// only while no reading is in progress.
module ntc_temperature_cutoff
   import ntc_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
   parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
   parameter int CHANNEL_COUNT       = CHANNEL_COUNT_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // sample[11:0], zero [15:12]
   input  logic [CH_W-1:0]      req_tuser,   // channel[1:0]

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // temperature[6:0], out_of_range[7],
                                             // power_mask[10:8], zero [15:11]
   output logic [CH_W-1:0]      rsp_tuser,   // reading_channel[1:0]

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data
);

   acc_status_type     acc_status;
   eng_status_type     eng_status;

   logic               accept, ch_ok, start, take, out_free, over;
   logic [CH_W-1:0]    cur_ch_ff;
   logic [LIMIT_W-1:0] limit_ff [CHAN_MAX];
   logic [LIMIT_W-1:0] cur_limit;
   logic [MASK_W-1:0]  enable_ff, enable_in, ch_bit;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_tdata_ff;
   logic [CH_W-1:0]    rsp_tuser_ff;

   assign req_tready = eng_status.idle;
   assign accept     = req_tvalid & req_tready;
   assign ch_ok      = (req_tuser < CH_W'(CHANNEL_COUNT));
   assign start      = accept & ch_ok & acc_status.complete;

   ntc_accum #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING),
      .CHANNEL_COUNT       (CHANNEL_COUNT)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .channel (req_tuser),
      .sample  (req_tdata[SAMPLE_W-1:0]),
      .status  (acc_status)
   );

   ntc_engine #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING),
      .TABLE_ENTRIES       (TABLE_ENTRIES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .total  (acc_status.total),
      .take   (take),
      .status (eng_status)
   );

   // Hold the channel of the reading in flight
   always_ff @(posedge clock) begin
      if (start) begin
         cur_ch_ff <= req_tuser;
      end
   end

   // Alarm limit registers; the port never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHAN_MAX; c++) begin
            limit_ff[c] <= LIMIT_RESET;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ALARM_LIMIT_CH0: limit_ff[0] <= csr_data;
            CSR_ALARM_LIMIT_CH1: limit_ff[1] <= csr_data;
            CSR_ALARM_LIMIT_CH2: limit_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cur_ch_ff)
         CH0:     cur_limit = limit_ff[0];
         CH1:     cur_limit = limit_ff[1];
         CH2:     cur_limit = limit_ff[2];
         default: cur_limit = limit_ff[0];
      endcase
   end

   // Move the finished reading into the output register when it is free
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign take     = eng_status.res_valid & out_free;
   assign over     = (eng_status.temp >= cur_limit);
   assign ch_bit   = MASK_W'(1) << cur_ch_ff;

   always_comb begin
      enable_in    = enable_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (take) begin
         enable_in    = over ? (enable_ff & ~ch_bit) : (enable_ff | ch_bit);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_tdata_ff <= {5'd0, enable_in, eng_status.oor, eng_status.temp};
         rsp_tuser_ff <= cur_ch_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A finished reading always shows up on the output next cycle
   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("finished reading not presented on rsp");

   // Power mask changes only when a reading completes
   a_mask_stable: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(enable_ff))
      else $error("power mask changed without a reading");

   // A lookup blocks new samples until it is delivered
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("sample accepted during a lookup");

endmodule

// File: hdl/ntc_alu.sv
// Shared compare unit used by the curve end checks and the curve search.
module ntc_alu
   import ntc_pkg::*;
(
   input  logic [SUM_W-1:0] op_a,
   input  logic [SUM_W-1:0] op_b,
   output logic             ge
);

   assign ge = (op_a >= op_b);

endmodule

// File: hdl/ntc_accum.sv
// Per-channel sample sums and counts.
module ntc_accum
   import ntc_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
   parameter int CHANNEL_COUNT       = CHANNEL_COUNT_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [CH_W-1:0]     channel,
   input  logic [SAMPLE_W-1:0] sample,
   output acc_status_type      status
);

   localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

   logic [SUM_W-1:0] sum_ff [CHANNEL_COUNT];
   logic [CNT_W-1:0] cnt_ff [CHANNEL_COUNT];
   logic [SUM_W-1:0] sel_sum;
   logic [CNT_W-1:0] sel_cnt;
   logic [CNT_W:0]   cnt_next;

   always_comb begin
      sel_sum = '0;
      sel_cnt = '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (channel == CH_W'(c)) begin
            sel_sum = sum_ff[c];
            sel_cnt = cnt_ff[c];
         end
      end
      cnt_next        = {1'b0, sel_cnt} + (CNT_W+1)'(1);
      status.complete = (cnt_next == (CNT_W+1)'(SAMPLES_PER_READING));
      status.total    = sel_sum + SUM_W'(sample);
   end

   // Clear on the reading's last sample, else store the running sum
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (reset) begin
            sum_ff[c] <= '0;
            cnt_ff[c] <= '0;
         end else if (accept && channel == CH_W'(c)) begin
            if (status.complete) begin
               sum_ff[c] <= '0;
               cnt_ff[c] <= '0;
            end else begin
               sum_ff[c] <= status.total;
               cnt_ff[c] <= cnt_next[CNT_W-1:0];
            end
         end
      end
   end

endmodule

// File: hdl/ntc_engine.sv
// Sequencer for the reciprocal-multiply average and the binary curve search.
module ntc_engine
   import ntc_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
   parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] total,
   input  logic             take,
   output eng_status_type   status
);

   localparam int TBL_A  = (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
   localparam int TBL_N  = (TBL_A > ROM_SIZE) ? ROM_SIZE : TBL_A;
   localparam int IDX_W  = $clog2(TBL_N);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_N - 1);

   // Scaled reciprocal, rounded up, exact for every 16-bit sum
   localparam int DIV_SH    = SUM_W + $clog2(SAMPLES_PER_READING);
   localparam int DIV_MUL_I = ((1 << DIV_SH) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
   localparam logic [SUM_W:0] DIV_MUL = (SUM_W+1)'(DIV_MUL_I);
   localparam int PROD_W    = DIV_SH + SUM_W;

   eng_state_type    state_ff, state_in;
   logic [SUM_W-1:0] num_ff, num_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in, temp_ff, temp_in;
   logic             oor_ff, oor_in;

   logic [SUM_W-1:0]  op_a, op_b;
   logic              ge;
   logic [PROD_W-1:0] prod;
   logic [IDX_W:0]    mid_sum;
   logic [IDX_W-1:0]  mid;

   ntc_alu u_alu (
      .op_a (op_a),
      .op_b (op_b),
      .ge   (ge)
   );

   assign prod    = PROD_W'(num_ff) * PROD_W'(DIV_MUL);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff  <= num_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      temp_ff <= temp_in;
      oor_ff  <= oor_in;
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      temp_in  = temp_ff;
      oor_in   = oor_ff;
      op_a     = num_ff;
      op_b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = total;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // Average in one step: multiply by the reciprocal, keep the high bits
            num_in   = prod[DIV_SH +: SUM_W];
            state_in = ST_CHK_LOW;
         end
         ST_CHK_LOW: begin
            op_b = SUM_W'(curve_at('0));
            if (!ge) begin
               temp_in  = '0;
               oor_in   = 1'b1;
               state_in = ST_HOLD;
            end else begin
               state_in = ST_CHK_HIGH;
            end
         end
         ST_CHK_HIGH: begin
            op_b = SUM_W'(curve_at(ROM_IDX_W'(LAST_IDX)));
            if (ge) begin
               temp_in  = LAST_IDX;
               oor_in   = 1'b1;
               state_in = ST_HOLD;
            end else begin
               lo_in    = '0;
               hi_in    = LAST_IDX;
               oor_in   = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Keep curve[lo] <= avg < curve[hi]; narrow until adjacent
            op_b = SUM_W'(curve_at(ROM_IDX_W'(mid)));
            if ((hi_ff - lo_ff) == IDX_W'(1)) begin
               temp_in  = lo_ff;
               state_in = ST_HOLD;
            end else if (ge) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
         end
         ST_HOLD: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.res_valid = (state_ff == ST_HOLD);
   assign status.temp      = TEMP_W'(temp_ff);
   assign status.oor       = oor_ff;

endmodule

// File: tb/tb_ntc_temperature_cutoff.sv
// Self-checking testbench for the three-channel NTC temperature cutoff.
`timescale 1ns / 1ps

module tb_ntc_temperature_cutoff;
   import ntc_pkg::*;

   // Codes that the package does not name: the unused channel and register index
   localparam logic [CH_W-1:0]      CH_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Settle well beyond the length of a lookup
   localparam int SETTLE_CYCLES = 48;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 106;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC
   } rx_mode_type;

   // One completed reading as it leaves the block
   typedef struct packed {
      logic [CH_W-1:0]   chan;
      logic [TEMP_W-1:0] temp;
      logic              oor;
      logic [MASK_W-1:0] mask;
   } reading_type;

   // Tracks per-channel sums and the enable mask; queues the readings to come
   class cutoff_scoreboard;
      logic [LIMIT_W-1:0] limit [3];
      logic [SUM_W-1:0]   sum [3];
      logic [3:0]         count [3];
      logic [MASK_W-1:0]  enables;
      reading_type        pending_readings [$];
      int                 fails;

      function new();
         foreach (limit[i]) begin
            limit[i] = LIMIT_RESET;
            sum[i]   = '0;
            count[i] = '0;
         end
         enables = '0;
         fails   = 0;
      endfunction

      function void write_limit(logic [CSR_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
         if (idx <= CSR_ALARM_LIMIT_CH2) begin
            limit[idx] = val;
         end
      endfunction

      // Degree interval of an average; clamp to the curve ends with a flag
      function logic [TEMP_W-1:0] degree_of(int unsigned avg, output logic oor);
         int i;
         oor = 1'b1;
         if (avg < CURVE_ROM[0]) begin
            return '0;
         end
         if (avg >= CURVE_ROM[ROM_SIZE-1]) begin
            return TEMP_W'(ROM_SIZE - 1);
         end
         oor = 1'b0;
         for (i = 0; i < ROM_SIZE - 1; i++) begin
            if (avg < CURVE_ROM[i+1]) begin
               return TEMP_W'(i);
            end
         end
         return '0;
      endfunction

      function void note_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
         logic [SUM_W-1:0] total;
         logic [4:0]       n;
         logic             oor;
         reading_type      r;
         if (ch >= CHANNEL_COUNT_DEF) begin
            return;
         end
         total = sum[ch] + SUM_W'(smp);
         n = 5'(count[ch]) + 5'd1;
         if (n < SAMPLES_PER_READING_DEF) begin
            sum[ch]   = total;
            count[ch] = n[3:0];
            return;
         end
         sum[ch]   = '0;
         count[ch] = '0;
         r.temp = degree_of(int'(total) / SAMPLES_PER_READING_DEF, oor);
         r.oor  = oor;
         if (r.temp >= limit[ch]) begin
            enables[ch] = 1'b0;
         end else begin
            enables[ch] = 1'b1;
         end
         r.chan = ch;
         r.mask = enables;
         pending_readings.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
         end
      endfunction

      function void check_reading(logic [CH_W-1:0] chan, logic [15:0] data);
         reading_type want;
         if (pending_readings.size() == 0) begin
            $display("%0t ns: unexpected reading, expected none, actual ch %0d data 0x%h",
                     $time, chan, data);
            fails++;
            return;
         end
         want = pending_readings.pop_front();
         compare_field("reading_channel", want.chan, chan);
         compare_field("temperature", want.temp, data[TEMP_W-1:0]);
         compare_field("out_of_range", want.oor, data[TEMP_W]);
         compare_field("power_mask", want.mask, data[TEMP_W+1 +: MASK_W]);
      endfunction

      function int outstanding();
         return pending_readings.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // sample[11:0], zero [15:12]
   logic [CH_W-1:0]      req_tuser  = '0;   // channel[1:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // temperature[6:0], out_of_range[7],
                                            // power_mask[10:8], zero [15:11]
   logic [CH_W-1:0]      rsp_tuser;         // reading_channel[1:0]
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [LIMIT_W-1:0]   csr_data   = '0;

   cutoff_scoreboard sb = new();

   rx_mode_type rx_mode = RX_ALWAYS;
   int unsigned rx_count = 0;
   int unsigned cycle_count = 0;

   // Stimulus bookkeeping: where each channel stands in its own reading
   int stim_count [3] = '{0, 0, 0};
   int stim_centre [3];
   int stim_spread [3];

   ntc_temperature_cutoff i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: stall on a pattern chosen per phase
   always @(posedge clock) begin
      rx_count <= rx_count + 1;
      case (rx_mode)
         RX_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            // ready early in each repeating period of rx_count, stalled for the rest
            rsp_tready <= ((rx_count % 11) < 4);
         end
      endcase
   end

   // Check every accepted reading against the oldest one predicted
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         sb.check_reading(rsp_tuser, rsp_tdata);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Present one sample and hold it until accepted; leave tvalid high on return
   task automatic send_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      req_tvalid <= 1'b1;
      req_tdata  <= 16'(smp);
      req_tuser  <= ch;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_sample(ch, smp);
   endtask

   // Drop tvalid for a number of cycles
   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Hold off the sender until every predicted reading has come out, then settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Present one register write; the caller drops csr_valid after the last one
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_limit(idx, val);
   endtask

   task automatic program_limits(logic [LIMIT_W-1:0] l0, logic [LIMIT_W-1:0] l1,
                                 logic [LIMIT_W-1:0] l2);
      write_reg(CSR_ALARM_LIMIT_CH0, l0);
      write_reg(CSR_ALARM_LIMIT_CH1, l1);
      write_reg(CSR_ALARM_LIMIT_CH2, l2);
      // the unused index must leave every limit alone
      write_reg(CSR_UNUSED, LIMIT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 7'd120;
         2: return 7'd127;
         3: return LIMIT_RESET;
         default: return LIMIT_W'($urandom_range(0, 127));
      endcase
   endfunction

   // Average that a reading aims for: mostly inside the curve, often on an entry
   function automatic int pick_centre();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) begin
         return $urandom_range(282, 966);
      end else if (p < 75) begin
         return int'(CURVE_ROM[$urandom_range(0, ROM_SIZE - 1)]) - int'($urandom_range(0, 1));
      end else if (p < 90) begin
         case ($urandom_range(0, 5))
            0: return 0;
            1: return 281;
            2: return 282;
            3: return 966;
            4: return 967;
            default: return 4095;
         endcase
      end
      return $urandom_range(0, 4095);
   endfunction

   function automatic logic [SAMPLE_W-1:0] near(int centre, int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_W'(v);
   endfunction

   // Random samples in bursts; mostly well-formed readings, some noise
   task automatic send_stream(int items, int gap_max);
      int               burst;
      int               r;
      logic [CH_W-1:0]  ch;
      logic [SAMPLE_W-1:0] smp;
      burst = $urandom_range(1, 24);
      repeat (items) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            ch  = CH_UNUSED;
            smp = SAMPLE_W'($urandom);
         end else begin
            ch = CH_W'($urandom_range(0, CHANNEL_COUNT_DEF - 1));
            if (stim_count[ch] == 0) begin
               stim_centre[ch] = pick_centre();
               // a flat reading lands its average on the target unless a noise sample is mixed in
               stim_spread[ch] = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40);
            end
            if (r < 10) begin
               smp = SAMPLE_W'($urandom);
            end else begin
               smp = near(stim_centre[ch], stim_spread[ch]);
            end
            stim_count[ch] = (stim_count[ch] + 1) % SAMPLES_PER_READING_DEF;
         end
         send_sample(ch, smp);
         burst--;
         if (burst == 0) begin
            if (gap_max > 0) begin
               idle_gap($urandom_range(0, gap_max));
            end
            burst = $urandom_range(1, 24);
         end
      end
   endtask

   initial begin
      int phase;
      int gap_max;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: floor and ceiling of the sample on two channels under the
      // reset limits, with the unused channel code mixed in
      for (int k = 0; k < SAMPLES_PER_READING_DEF; k++) begin
         send_sample(CH0, '0);
         send_sample(CH1, '1);
         if (k == 4) begin
            send_sample(CH_UNUSED, '1);
            send_sample(CH_UNUSED, '0);
         end
      end

      for (phase = 1; phase <= PHASE_COUNT; phase++) begin
         wait_drained();
         // limits of zero, the top degree and above the table on each channel
         case (phase)
            1: program_limits(7'd0, 7'd127, 7'd120);
            2: program_limits(7'd120, 7'd0, 7'd127);
            3: program_limits(7'd127, 7'd120, 7'd0);
            default: program_limits(pick_limit(), pick_limit(), pick_limit());
         endcase
         rx_mode = rx_mode_type'(phase % 3);
         gap_max = 20;
         // one stretch with no idling on either side
         if (phase == 3) begin
            rx_mode = RX_ALWAYS;
            gap_max = 0;
         end
         if (phase == 5) begin
            send_stream(PHASE_ITEMS / 2, gap_max);
            wait_drained();
            send_stream(PHASE_ITEMS - PHASE_ITEMS / 2, gap_max);
         end else begin
            send_stream(PHASE_ITEMS, gap_max);
         end
      end

      wait_drained();
      if (sb.fails == 0 && sb.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
